// File: rtl/core/rpse_pkg.sv
// Shared types and constants for the row projection shift estimator.
// No dependencies.
`default_nettype none
package rpse_pkg;
    localparam int unsigned ACC_W = 22;
    localparam logic [ACC_W-1:0] ACC_MAX = 22'd4194303;
    localparam int unsigned SHIFT_W = 7;
    localparam int unsigned CUM_W = 21;
    localparam int unsigned REV_W = 16;
    localparam int unsigned MS_W = 6;
    localparam logic [MS_W-1:0] MAX_SHIFT_RST = 6'd60;

    // Request passed from the front to the back part: one finished frame.
    typedef struct packed {
        logic [12:0] rows;
        logic        baseline;
    } frame_req_t;
endpackage
`default_nettype wire

// File: rtl/core/rpse_front.sv
// Front part: sums pixels into row projections, writes rows to the current buffer.
// Depends on rpse_pkg.
`default_nettype none
module rpse_front
    import rpse_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 1024,
    parameter int unsigned ROW_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              px_valid,
    output logic                   px_ready,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              last_in_row,
    input  wire logic              last_in_frame,
    output logic                   wr_en,
    output logic [ROW_W-1:0]       wr_addr,
    output logic [ACC_W-1:0]       wr_data,
    output logic                   req_valid,
    input  wire logic              req_ready,
    output frame_req_t             req
);
    logic [ACC_W-1:0] acc_reg, acc_next, acc_sum;
    logic [12:0]      cnt_reg, cnt_next;
    logic             base_reg, base_next;
    logic             fire, row_end;
    logic [23:0]      wide;

    // Back part owns the buffer until its frame is done; hold row ends until it is idle.
    assign row_end  = last_in_row || last_in_frame;
    assign px_ready = req_ready || !row_end;
    assign fire     = px_valid && px_ready;

    always_comb begin
        wide    = {2'b0, acc_reg} + 24'(red) + 24'(green) + 24'(blue);
        acc_sum = (wide > 24'(ACC_MAX)) ? ACC_MAX : wide[ACC_W-1:0];
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        base_next = base_reg;
        wr_en     = 1'b0;
        wr_addr   = cnt_reg[ROW_W-1:0];
        wr_data   = acc_sum;
        req_valid = 1'b0;
        req.rows  = cnt_reg;
        req.baseline = !base_reg;
        if (fire) begin
            acc_next = acc_sum;
            if (row_end) begin
                acc_next = '0;
                if (cnt_reg < 13'(MAX_ROWS)) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 13'd1;
                    req.rows = cnt_reg + 13'd1;
                end
            end
            if (last_in_frame) begin
                req_valid = 1'b1;
                cnt_next  = '0;
                base_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            base_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            base_reg <= base_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/rpse_back.sv
// Back part: copies or searches shifts over the stored projections, forms results.
// Depends on rpse_pkg.
`default_nettype none
module rpse_back
    import rpse_pkg::*;
#(
    parameter int unsigned ROW_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [MS_W-1:0]   max_shift,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire frame_req_t        req,
    input  wire logic [ACC_W-1:0]  cur_data,
    output logic [ROW_W-1:0]       cur_addr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [SHIFT_W-1:0] m_shift,
    output logic signed [CUM_W-1:0]   m_cumulative_shift,
    output logic                   m_reversal,
    output logic [REV_W-1:0]       m_reversal_count
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COPY  = 7'b0000010,
        S_SINIT = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    localparam int unsigned DEPTH = 1 << ROW_W;
    localparam int unsigned SUM_W = ACC_W + ROW_W + 1;

    logic [ACC_W-1:0] prev_mem [DEPTH];
    logic [ACC_W-1:0] prev_q;

    state_t state_reg;
    logic [12:0] n_reg, y_reg, yy_reg, cnt_reg, best_cnt_reg;
    logic signed [7:0] s_reg, best_reg;
    logic [SUM_W-1:0] sum_reg, best_sum_reg;
    logic found_reg, copy_reg;
    logic [SUM_W+12:0] lhs_reg, rhs_reg;
    logic signed [SHIFT_W-1:0] last_nz_reg;
    logic signed [CUM_W-1:0]   cum_reg;
    logic [REV_W-1:0]          revs_reg;
    logic signed [7:0] lim;
    logic [7:0] mag;
    logic signed [14:0] lo, hi;
    logic acc_v_reg;
    logic [12:0] pidx_reg;
    logic signed [SHIFT_W-1:0] sh7;
    logic signed [CUM_W+1:0] cw;
    logic rev;
    logic prev_we;
    logic out_go;

    assign cur_addr = y_reg[ROW_W-1:0];
    assign req_ready = (state_reg == S_IDLE);
    assign lim = 8'(max_shift);
    assign sh7 = best_reg[SHIFT_W-1:0];
    assign prev_we = (state_reg == S_COPY) && acc_v_reg;
    // Advance out of the output step only once the output register is free.
    assign out_go = (state_reg == S_OUT) && (!m_valid || m_ready);

    // Pipelined read: cur_data and prev_q are each registered and follow their address in the next cycle.
    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[pidx_reg[ROW_W-1:0]] <= cur_data;
        prev_q <= prev_mem[yy_reg[ROW_W-1:0]];
    end

    always_comb begin
        mag = s_reg[7] ? 8'(-s_reg) : 8'(s_reg);
        lo  = (s_reg < 0) ? 15'(-s_reg) : 15'd0;
        hi  = (s_reg < 0) ? 15'(n_reg) : 15'(n_reg) - 15'(s_reg);
    end

    always_comb begin
        cw = (CUM_W+2)'(cum_reg) + (CUM_W+2)'(sh7);
        if (cw > (CUM_W+2)'(1048575)) cw = (CUM_W+2)'(1048575);
        if (cw < -(CUM_W+2)'(1048576)) cw = -(CUM_W+2)'(1048576);
        rev = sh7 != 0 && last_nz_reg != 0 && ((sh7 > 0) != (last_nz_reg > 0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            last_nz_reg <= '0;
            cum_reg   <= '0;
            revs_reg  <= '0;
            acc_v_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready && !out_go) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        n_reg <= req.rows;
                        copy_reg <= 1'b0;
                        y_reg <= '0;
                        acc_v_reg <= 1'b0;
                        if (req.baseline) begin
                            state_reg <= S_COPY;
                        end else begin
                            s_reg <= -lim;
                            found_reg <= 1'b0;
                            best_reg <= '0;
                            state_reg <= S_SINIT;
                        end
                    end
                end
                S_COPY: begin
                    // Read current at y, write previous in the following cycle.
                    acc_v_reg <= y_reg < n_reg;
                    pidx_reg  <= y_reg;
                    if (y_reg < n_reg) y_reg <= y_reg + 13'd1;
                    else if (!acc_v_reg) state_reg <= copy_reg ? S_OUT : S_IDLE;
                end
                S_SINIT: begin
                    if (s_reg > lim) begin
                        y_reg <= '0; acc_v_reg <= 1'b0; copy_reg <= 1'b1;
                        state_reg <= S_COPY;
                    end else if (13'(mag) >= n_reg) begin
                        s_reg <= s_reg + 8'sd1;
                    end else begin
                        y_reg <= 13'(lo + 15'(s_reg));
                        yy_reg <= 13'(lo);
                        sum_reg <= '0; cnt_reg <= '0;
                        acc_v_reg <= 1'b0;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    acc_v_reg <= 15'(yy_reg) < hi;
                    if (acc_v_reg) begin
                        sum_reg <= sum_reg + SUM_W'((prev_q > cur_data) ? prev_q - cur_data
                                                                         : cur_data - prev_q);
                        cnt_reg <= cnt_reg + 13'd1;
                    end
                    if (15'(yy_reg) < hi) begin
                        yy_reg <= yy_reg + 13'd1;
                        y_reg <= y_reg + 13'd1;
                    end else if (!acc_v_reg) state_reg <= S_MUL;
                end
                S_MUL: begin
                    lhs_reg <= sum_reg * best_cnt_reg;
                    rhs_reg <= best_sum_reg * cnt_reg;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (!found_reg || lhs_reg < rhs_reg) begin
                        found_reg <= 1'b1;
                        best_sum_reg <= sum_reg;
                        best_cnt_reg <= cnt_reg;
                        best_reg <= s_reg;
                    end
                    s_reg <= s_reg + 8'sd1;
                    state_reg <= S_SINIT;
                end
                S_OUT: begin
                    if (out_go) begin
                        cum_reg <= cw[CUM_W-1:0];
                        m_cumulative_shift <= cw[CUM_W-1:0];
                        m_shift <= sh7;
                        m_reversal <= rev;
                        if (rev && revs_reg != '1) begin
                            revs_reg <= revs_reg + 1'b1;
                            m_reversal_count <= revs_reg + 1'b1;
                        end else m_reversal_count <= revs_reg;
                        if (sh7 != 0) last_nz_reg <= sh7;
                        m_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/row_projection_shift_estimator.sv
// Row projection shift estimator top level: front, current row buffer, back.
// Depends on rpse_pkg, rpse_front, rpse_back.
//
// Pixels enter on s_ (valid/ready), one per cycle. Plain pixels keep flowing
// while the back part works, but a row-end or frame-end pixel is held until
// the back part is idle, since the current row buffer has one owner at a time.
// Each row's R+G+B sum is stored; the first frame only becomes the baseline
// (a copy pass, no result). At each later frame end the back part searches
// shifts -max_shift..max_shift: a shift without overlap is skipped, one with
// overlap m reads its m rows through the single read port of each row buffer.
// A copy pass and an output step follow, and then one result is given on m_
// (valid/ready).
// While a result waits on m_ready the back part can take the next frame and
// stops at its output step until the waiting result is taken.
// Reset (aresetn low, synchronous) clears counters, baseline and running
// totals and sets max_shift to 60; row buffers are undefined until written.
`default_nettype none
module row_projection_shift_estimator
    import rpse_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [MS_W-1:0]   cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_red,
    input  wire logic [7:0]        s_green,
    input  wire logic [7:0]        s_blue,
    input  wire logic              s_last_in_row,
    input  wire logic              s_last_in_frame,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [SHIFT_W-1:0] m_shift,
    output logic signed [CUM_W-1:0]   m_cumulative_shift,
    output logic                   m_reversal,
    output logic [REV_W-1:0]       m_reversal_count
);
    localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [MS_W-1:0] max_shift_reg;
    logic wr_en, req_valid, req_ready;
    logic [ROW_W-1:0] wr_addr, rd_addr;
    logic [ACC_W-1:0] wr_data, rd_data;
    frame_req_t req;
    logic [ACC_W-1:0] cur_mem [1<<ROW_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) max_shift_reg <= MAX_SHIFT_RST;
        else if (cfg_we) max_shift_reg <= cfg_wdata;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) cur_mem[wr_addr] <= wr_data;
        rd_data <= cur_mem[rd_addr];
    end

    rpse_front #(.MAX_ROWS(MAX_ROWS), .ROW_W(ROW_W)) u_front (
        .aclk, .aresetn, .px_valid(s_valid), .px_ready(s_ready),
        .red(s_red), .green(s_green), .blue(s_blue),
        .last_in_row(s_last_in_row), .last_in_frame(s_last_in_frame),
        .wr_en, .wr_addr, .wr_data, .req_valid, .req_ready, .req
    );

    rpse_back #(.ROW_W(ROW_W)) u_back (
        .aclk, .aresetn, .max_shift(max_shift_reg), .req_valid, .req_ready, .req,
        .cur_data(rd_data), .cur_addr(rd_addr), .m_valid, .m_ready, .m_shift,
        .m_cumulative_shift, .m_reversal, .m_reversal_count
    );
endmodule
`default_nettype wire

// File: rtl/core/rpse_checker.sv
// Port-level checks for row_projection_shift_estimator, bound to the top level.
// Depends on rpse_pkg.
`default_nettype none
module rpse_checker
    import rpse_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [SHIFT_W-1:0] m_shift,
    input wire logic [REV_W-1:0] m_reversal_count,
    input wire logic m_reversal
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shift)) else $error("result dropped");
    a_rev0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reversal |-> m_shift != '0) else $error("reversal on zero shift");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reversal && m_reversal_count != '1 |-> m_reversal_count != '0)
        else $error("count missed reversal");
endmodule
bind row_projection_shift_estimator rpse_checker u_chk (.aclk, .aresetn, .m_valid,
    .m_ready, .m_shift, .m_reversal_count, .m_reversal);
`default_nettype wire

// File: test/tb_row_projection_shift_estimator.sv
// Testbench for row_projection_shift_estimator: drives pixel frames and checks
// every per-frame shift result against an in-bench predictor. Depends on rpse_pkg.
`timescale 1ns / 100ps
module tb_row_projection_shift_estimator;
    import rpse_pkg::*;

    localparam int NROWS = 1024;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift;
        logic signed [CUM_W-1:0]   cumulative_shift;
        logic                      reversal;
        logic [REV_W-1:0]          reversal_count;
    } shift_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [MS_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_red = '0, s_green = '0, s_blue = '0;
    logic s_last_in_row = 1'b0, s_last_in_frame = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SHIFT_W-1:0] m_shift;
    logic signed [CUM_W-1:0] m_cumulative_shift;
    logic m_reversal;
    logic [REV_W-1:0] m_reversal_count;

    row_projection_shift_estimator u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_red(s_red), .s_green(s_green),
        .s_blue(s_blue), .s_last_in_row(s_last_in_row),
        .s_last_in_frame(s_last_in_frame), .m_valid(m_valid), .m_ready(m_ready),
        .m_shift(m_shift), .m_cumulative_shift(m_cumulative_shift),
        .m_reversal(m_reversal), .m_reversal_count(m_reversal_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [ACC_W-1:0] prev_proj [NROWS];
    logic [ACC_W-1:0] cur_proj [NROWS];
    logic [ACC_W-1:0] row_sum;
    int unsigned rows_seen;
    bit baseline_done;
    int last_nz_shift;
    int running_total;
    int unsigned reversal_total;
    int unsigned search_limit;

    shift_result_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int pixels_sent = 0;
    bit idle_enable = 1'b1;
    bit finished = 1'b0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
        errors++;
    endtask

    function automatic int best_shift(input int n, input int lim);
        bit found;
        longint best_sum, best_cnt, sum, cnt;
        int best, mag, yy;
        found = 0; best_sum = 0; best_cnt = 1; best = 0;
        for (int s = -lim; s <= lim; s++) begin
            mag = s < 0 ? -s : s;
            if (mag >= n) continue;
            sum = 0; cnt = 0;
            for (int y = 0; y < n; y++) begin
                yy = y + s;
                if (yy < 0 || yy >= n) continue;
                sum += prev_proj[y] > cur_proj[yy] ? prev_proj[y] - cur_proj[yy]
                                                   : cur_proj[yy] - prev_proj[y];
                cnt++;
            end
            if (!found || sum * best_cnt < best_sum * cnt) begin
                found = 1; best_sum = sum; best_cnt = cnt; best = s;
            end
        end
        return best;
    endfunction

    task automatic predict_pixel(input logic [7:0] r, g, b, input logic eor, eof);
        int unsigned acc;
        int n, s, cum;
        bit rev;
        shift_result_t res;
        acc = row_sum + r + g + b;
        row_sum = acc > ACC_MAX ? ACC_MAX : acc[ACC_W-1:0];
        if (eor || eof) begin
            if (rows_seen < NROWS) begin
                cur_proj[rows_seen] = row_sum;
                rows_seen++;
            end
            row_sum = '0;
        end
        if (!eof) return;
        n = rows_seen;
        rows_seen = 0;
        if (baseline_done) begin
            s = best_shift(n, search_limit);
            cum = running_total + s;
            if (cum > 1048575) cum = 1048575;
            if (cum < -1048576) cum = -1048576;
            running_total = cum;
            rev = s != 0 && last_nz_shift != 0 && ((s > 0) != (last_nz_shift > 0));
            if (rev && reversal_total < 65535) reversal_total++;
            if (s != 0) last_nz_shift = s;
            res.shift = SHIFT_W'(s);
            res.cumulative_shift = CUM_W'(cum);
            res.reversal = rev;
            res.reversal_count = reversal_total[REV_W-1:0];
            expected_q.push_back(res);
        end
        baseline_done = 1'b1;
        for (int y = 0; y < n; y++) prev_proj[y] = cur_proj[y];
    endtask

    task automatic send_pixel(input logic [7:0] r, g, b, input logic eor, eof);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red <= r; s_green <= g; s_blue <= b;
        s_last_in_row <= eor; s_last_in_frame <= eof;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(r, g, b, eor, eof);
        pixels_sent++;
    endtask

    // drop valid after the last accepted request
    task automatic hold_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Send one frame: rows of the given width. offset shifts the row pattern so
    // frames can be shifted copies of a pattern.
    task automatic send_frame(input int nrows, input int width, input int offset,
                              input int seed, input bit noisy);
        logic [7:0] v;
        for (int y = 0; y < nrows; y++) begin
            for (int x = 0; x < width; x++) begin
                v = noisy ? 8'($urandom) : 8'(((y - offset) * 37 + seed) * 13 + x);
                send_pixel(v, 8'(v * 3), 8'(v ^ 8'h5a), x == width - 1,
                           (y == nrows - 1) && (x == width - 1));
            end
        end
    endtask

    task automatic drain_and_settle();
        hold_input();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_max_shift(input logic [MS_W-1:0] val);
        drain_and_settle();
        cfg_we <= 1'b1; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        search_limit = val;
    endtask

    task automatic test_directed_edges();
        // baseline tall enough that later frames only read stored rows, then
        // extremes of channel values and an end-of-frame pixel that does not
        // also mark end of row
        send_frame(8, 2, 0, 1, 0);
        send_pixel(8'hff, 8'hff, 8'hff, 1, 0);
        send_pixel(8'h00, 8'h00, 8'h00, 1, 0);
        send_pixel(8'h80, 8'h01, 8'hfe, 0, 0);
        send_pixel(8'h7f, 8'h55, 8'haa, 0, 1);
        send_frame(3, 2, 1, 1, 0);
        send_frame(3, 2, 0, 1, 0);
        // single-row frame: only shift zero overlaps
        send_frame(1, 3, 0, 2, 0);
        send_frame(1, 2, 0, 4, 0);
    endtask

    task automatic test_max_shift_settings();
        write_max_shift(6'd0);
        send_frame(5, 2, 1, 5, 0);
        write_max_shift(6'd63);
        send_frame(5, 2, 2, 5, 0);
        send_frame(5, 2, 0, 5, 0);
        write_max_shift(6'd2);
        send_frame(6, 1, -1, 5, 0);
    endtask

    task automatic test_long_rows();
        // a couple of wide rows, sums stay under saturation at these widths
        send_frame(2, 40, 0, 9, 1);
        send_frame(2, 40, 0, 9, 1);
    endtask

    task automatic test_random_frames();
        int nrows, width, off;
        while (pixels_sent < 520) begin
            nrows = $urandom_range(1, 8);
            width = $urandom_range(1, 4);
            off = $urandom_range(0, 4) - 2;
            if (pixels_sent > 260 && $urandom_range(0, 3) == 0) begin
                // hold off until every pending result has arrived
                hold_input();
                while (expected_q.size() != 0) @(posedge aclk);
            end
            if (pixels_sent > 420) idle_enable = 1'b0;
            send_frame(nrows, width, off, $urandom_range(0, 3), $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic test_reversal_run();
        write_max_shift(6'd3);
        for (int k = 0; k < 6; k++) send_frame(7, 1, (k % 2) ? 2 : -2, 3, 0);
    endtask

    // result checking and result-side stalls
    initial begin : result_checker
        shift_result_t want;
        int stall;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result shift", m_shift, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_shift !== want.shift)
                        report_mismatch("shift", m_shift, want.shift);
                    if (m_cumulative_shift !== want.cumulative_shift)
                        report_mismatch("cumulative_shift", m_cumulative_shift,
                                        want.cumulative_shift);
                    if (m_reversal !== want.reversal)
                        report_mismatch("reversal", m_reversal, want.reversal);
                    if (m_reversal_count !== want.reversal_count)
                        report_mismatch("reversal_count", m_reversal_count,
                                        want.reversal_count);
                end
                results_seen++;
            end
            if (idle_enable && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= aresetn;
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !finished) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        row_sum = '0; rows_seen = 0; baseline_done = 0; last_nz_shift = 0;
        running_total = 0; reversal_total = 0; search_limit = MAX_SHIFT_RST;
        for (int i = 0; i < NROWS; i++) begin
            prev_proj[i] = '0; cur_proj[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_max_shift_settings();
        test_long_rows();
        test_reversal_run();
        write_max_shift(6'd60);
        test_random_frames();
        drain_and_settle();
        finished = 1'b1;
        $display("sent %0d pixels, checked %0d frame results", pixels_sent, results_seen);
        $display("covered max_shift 0/2/3/60/63, single-row and noisy frames, reversals");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
